FILE: rtl/text_terminal_writer_defines.svh
// Assertion macros for the text terminal writer.
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_terminal_writer: implication violated");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("text_terminal_writer: forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: rtl/ttw_pkg.sv
// Shared types and constants of the text terminal writer.
`default_nettype none

package ttw_pkg;

  localparam logic [1:0] CMD_PUT     = 2'd0;
  localparam logic [1:0] CMD_SET_COL = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  COLOR_RESET  = 8'd7;
  localparam logic [15:0] BLANK_CELL   = {COLOR_RESET, SPACE_CODE};

  localparam int QUEUE_DEPTH = 2;

  // One classified command on its way to the screen store.
  typedef struct packed {
    logic        wr;
    logic        scroll;
    logic        rd;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [15:0] wdata;
    logic [4:0]  row_now;
    logic [6:0]  col_now;
  } ttw_op_t;

  typedef struct packed {
    logic clearing;
    logic out_load;
  } ttw_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCROLL,
    ST_READ,
    ST_DONE
  } ttw_state_t;

endpackage

`default_nettype wire

FILE: rtl/ttw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ttw_front.sv
// Front end: accepts commands, tracks the cursor and classifies store work.
`default_nettype none

module ttw_front import ttw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] char_code,
  input  wire logic [6:0] new_column,
  input  wire logic [4:0] cell_row,
  input  wire logic [6:0] cell_column,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire logic       q_full,
  input  wire logic       clearing,
  output      logic       push,
  output      ttw_op_t    push_op
);

  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);

  logic [4:0] row;
  logic [6:0] col;
  logic [7:0] text_color;
  logic [4:0] row_next;
  logic [6:0] col_next;
  logic       advance_row;
  ttw_op_t    op;

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;
  assign push_op  = op;

  always_comb begin
    op          = '0;
    row_next    = row;
    col_next    = col;
    advance_row = 1'b0;
    case (cmd)
      CMD_PUT: begin
        op.wr       = (char_code != NEWLINE_CODE);
        op.row      = row;
        op.col      = col;
        op.wdata    = {text_color, char_code};
        advance_row = (char_code == NEWLINE_CODE) || (col == LAST_COL);
        if (advance_row) begin
          col_next = '0;
          if (row == LAST_ROW) begin
            op.scroll = 1'b1;
          end else begin
            row_next = row + 5'd1;
          end
        end else begin
          col_next = col + 7'd1;
        end
      end
      CMD_SET_COL: begin
        col_next = (new_column > LAST_COL) ? LAST_COL : new_column;
      end
      CMD_READ: begin
        op.rd  = ({1'b0, cell_row} < 6'(ROWS)) && ({1'b0, cell_column} < 8'(COLUMNS));
        op.row = cell_row;
        op.col = cell_column;
      end
      default: ;
    endcase
    op.row_now = row_next;
    op.col_now = col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      text_color <= COLOR_RESET;
    end else begin
      if (push) begin
        row <= row_next;
        col <= col_next;
      end
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ttw_queue.sv
// Short queue of classified commands between front and back end.
`default_nettype none

module ttw_queue import ttw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire ttw_op_t push_op,
  output      logic    full,
  input  wire logic    pop,
  output      ttw_op_t head,
  output      logic    empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ttw_op_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ttw_back.sv
// Back end: clears, writes, scrolls and reads the screen store; holds the result.
`default_nettype none

module ttw_back import ttw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire ttw_op_t     q_head,
  output      logic        q_pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_cell,
  output      logic [4:0]  out_row,
  output      logic [6:0]  out_col,
  output      ttw_status_t status
);

  localparam int         DEPTH    = ROWS * COLUMNS;
  localparam int         AW       = $clog2(DEPTH);
  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);

  ttw_state_t    state;
  ttw_state_t    state_next;
  ttw_op_t       cur;
  logic [4:0]    top_row;
  logic [AW-1:0] clr_cnt;
  logic [6:0]    col_cnt;

  logic          take;
  logic [5:0]    row_sum;
  logic [5:0]    phys_row;
  logic [4:0]    row_sel;
  logic [6:0]    col_sel;
  logic [AW-1:0] cell_addr;
  logic          mem_we;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   mem_rdata;
  logic          out_load;
  logic [15:0]   cell_value;
  logic          scroll_last;

  assign take        = !q_empty && (!out_valid || out_ready);
  assign scroll_last = (col_cnt == LAST_COL);

  // Logical row maps onto the store through the rotating top-row pointer.
  assign row_sum  = {1'b0, cur.row} + {1'b0, top_row};
  assign phys_row = (row_sum >= 6'(ROWS)) ? row_sum - 6'(ROWS) : row_sum;

  always_comb begin
    if (state == ST_SCROLL) begin
      row_sel = top_row;
      col_sel = col_cnt;
    end else begin
      row_sel = phys_row[4:0];
      col_sel = cur.col;
    end
    if (state == ST_CLEAR) begin
      cell_addr = clr_cnt;
    end else begin
      cell_addr = AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          if (q_head.wr) begin
            state_next = ST_WRITE;
          end else if (q_head.scroll) begin
            state_next = ST_SCROLL;
          end else if (q_head.rd) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WRITE:  state_next = cur.scroll ? ST_SCROLL : ST_IDLE;
      ST_SCROLL: begin
        if (scroll_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ:   state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    cell_value = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = BLANK_CELL;
      end
      ST_IDLE:  q_pop = take;
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = cur.wdata;
        out_load  = !cur.scroll;
      end
      ST_SCROLL: begin
        mem_we   = 1'b1;
        out_load = scroll_last;
      end
      ST_READ:  mem_re = 1'b1;
      ST_DONE: begin
        out_load   = 1'b1;
        cell_value = cur.rd ? mem_rdata : '0;
      end
      default: ;
    endcase
  end

  ttw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cell_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cell_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (out_load) begin
      out_cell <= cell_value;
      out_row  <= cur.row_now;
      out_col  <= cur.col_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      col_cnt   <= '0;
      top_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_SCROLL) begin
        if (scroll_last) begin
          col_cnt <= '0;
          // The old top row, now cleared to zero, becomes the bottom row.
          top_row <= (top_row == LAST_ROW) ? '0 : top_row + 5'd1;
        end else begin
          col_cnt <= col_cnt + 7'd1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.clearing = (state == ST_CLEAR);
  assign status.out_load = out_load;

endmodule

`default_nettype wire

FILE: rtl/text_terminal_writer.sv
// Top level of the character-cell text terminal writer.
//
//  channel   | direction | transfer when          | contents
//  s_axis    | in        | tvalid & tready        | one command
//  m_axis    | out       | tvalid & tready        | one result per command
//  cfg       | in        | cfg_valid & cfg_ready  | text color attribute
//
// Each command passes through the back-end sequencer and its single store
// port. An off-screen read is handled like a set column or unused command;
// an on-screen read adds a store read before its result. A put that runs past
// the last row, or a newline there, adds a scroll zeroing the new bottom row.
// After reset the store is swept to blank cells with s_axis_tready low; cfg
// writes are taken throughout. A stalled m_axis holds its result while up to
// two commands queue behind it.
`default_nettype none
`include "text_terminal_writer_defines.svh"

module text_terminal_writer import ttw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // char_code[7:0], new_column[14:8], cell_row[19:15], cell_column[26:20]
  input  wire logic [31:0] s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_data[15:0], row_now[20:16], column_now[27:21]
  output      logic [31:0] m_axis_tdata,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic        push;
  ttw_op_t     push_op;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  ttw_op_t     q_head;
  ttw_status_t status;
  logic [15:0] out_cell;
  logic [4:0]  out_row;
  logic [6:0]  out_col;
  logic        row_ok;
  logic        col_ok;

  assign cfg_ready = 1'b1;

  ttw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .cmd         (s_axis_tuser),
    .char_code   (s_axis_tdata[7:0]),
    .new_column  (s_axis_tdata[14:8]),
    .cell_row    (s_axis_tdata[19:15]),
    .cell_column (s_axis_tdata[26:20]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .clearing    (status.clearing),
    .push        (push),
    .push_op     (push_op)
  );

  ttw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  ttw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_cell  (out_cell),
    .out_row   (out_row),
    .out_col   (out_col),
    .status    (status)
  );

  assign m_axis_tdata = {4'b0000, out_col, out_row, out_cell};

  assign row_ok = ({1'b0, out_row} < 6'(ROWS));
  assign col_ok = ({1'b0, out_col} < 8'(COLUMNS));

  `ASSERT_IMPLY(a_cursor_in_range, clk, rst, m_axis_tvalid, row_ok && col_ok)
  `ASSERT_NEVER(a_no_overwrite, clk, rst, status.out_load && m_axis_tvalid && !m_axis_tready)
  `ASSERT_IMPLY(a_quiet_while_clearing, clk, rst, status.clearing, !m_axis_tvalid && !q_pop)

endmodule

`default_nettype wire
